// File: rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
`default_nettype none

package stq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ID_W       = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int TIME_W     = 32;

    // request codes
    localparam logic [1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [1:0] REQ_CANCEL   = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_QUERY    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_SCHEDULED = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_EXPIRED   = 3'd2;
    localparam logic [2:0] ST_NONE      = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UNLINK,
        S_INSERT,
        S_TICK
    } state_t;

endpackage

`default_nettype wire

// File: rtl/sorted_timer_queue.sv
// Sorted timer queue: deadline-ordered list of timer slots with a walking sequencer.
//
//  channel  | handshake           | fields
//  ---------+---------------------+---------------------------------------------
//  request  | start, busy         | req_type, timer_id, delay, replace, now
//  result   | done (1-cycle pulse)| status, timer_id_res, interval, pending, last
//
// One 32-bit add/subtract unit serves every deadline sum and compare. Query, cancel of an
// idle slot and a rejected schedule answer the cycle after the word is taken, busy stays low.
// Cancel of a pending slot walks the list to unlink it. Schedule first walks it to unlink the
// old entry (replace only), then to the insert point, one list entry compared per cycle.
// Tick pops due timers off the head; each is held, shown with the next pop or at the end.
// Reset empties the list at once; no clearing pass. The receiver cannot stall results.
`default_nettype none

module sorted_timer_queue
    import stq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          req_type,
    input  wire logic [ID_W-1:0]     timer_id,
    input  wire logic [TIME_W-1:0]   delay,
    input  wire logic                replace,
    input  wire logic [TIME_W-1:0]   now,
    output logic                     done,
    output logic [2:0]               status,
    output logic [ID_W-1:0]          timer_id_res,
    output logic [TIME_W-1:0]        interval,
    output logic                     pending,
    output logic                     last
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [NUM_TIMERS-1:0]  valid_reg, valid_next;
    logic                   done_reg, done_next;
    logic                   hold_vld_reg, hold_vld_next;

    logic [ID_W-1:0]        order_reg [NUM_TIMERS];
    logic [ID_W-1:0]        order_next [NUM_TIMERS];
    logic [TIME_W-1:0]      deadline_reg [NUM_TIMERS];
    logic [TIME_W-1:0]      ival_reg [NUM_TIMERS];

    logic [ID_W-1:0]        idx_reg, idx_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [1:0]             req_reg, req_next;
    logic [TIME_W-1:0]      dl_reg, dl_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [ID_W-1:0]        hold_id_reg, hold_id_next;
    logic [TIME_W-1:0]      hold_ival_reg, hold_ival_next;

    logic [2:0]             status_reg, status_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic [TIME_W-1:0]      res_ival_reg, res_ival_next;
    logic                   res_pend_reg, res_pend_next;
    logic                   res_last_reg, res_last_next;

    logic                   accept;
    logic                   id_pending;
    logic [ID_W-1:0]        entry;
    logic [TIME_W-1:0]      rd_dl;
    logic [TIME_W-1:0]      op_a, op_b;
    logic                   op_sub;
    logic [TIME_W-1:0]      alu;
    logic                   match;
    logic                   at_end;
    logic                   place;
    logic                   due;
    logic                   dl_wr;

    assign accept     = start && !busy;
    assign id_pending = valid_reg[timer_id];
    assign entry      = order_reg[idx_reg];
    assign rd_dl      = deadline_reg[entry];

    // shared adder/subtractor: deadline sum at accept, compares while walking
    always_comb
    begin
        op_a   = now;
        op_b   = delay;
        op_sub = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                op_a   = now;
                op_b   = delay;
                op_sub = 1'b0;
            end
            S_INSERT:
            begin
                op_a   = dl_reg;
                op_b   = rd_dl;
                op_sub = 1'b1;
            end
            S_TICK:
            begin
                op_a   = rd_dl;
                op_b   = now_reg;
                op_sub = 1'b1;
            end
            default:
            begin
                op_a   = now;
                op_b   = delay;
                op_sub = 1'b0;
            end
        endcase
    end

    assign alu = op_a + (op_b ^ {TIME_W{op_sub}}) + {{(TIME_W-1){1'b0}}, op_sub};

    assign match  = (entry == id_reg);
    assign at_end = ({1'b0, idx_reg} == count_reg);
    // new deadline strictly earlier than this entry: goes in front of it
    assign place  = at_end || alu[TIME_W-1];
    assign due    = (count_reg != '0) && ((alu == '0) || alu[TIME_W-1]);
    assign dl_wr  = accept && (req_type == REQ_SCHEDULE) && (!id_pending || replace);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_SCHEDULE:
                            if (!id_pending)
                                state_next = S_INSERT;
                            else if (replace)
                                state_next = S_UNLINK;
                        REQ_CANCEL:
                            if (id_pending)
                                state_next = S_UNLINK;
                        REQ_TICK:
                            state_next = S_TICK;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_UNLINK:
            begin
                if (match || idx_reg == ID_W'(NUM_TIMERS - 1))
                    state_next = (req_reg == REQ_SCHEDULE) ? S_INSERT : S_IDLE;
            end
            S_INSERT:
            begin
                if (place || idx_reg == ID_W'(NUM_TIMERS - 1))
                    state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (!due)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and results
    always_comb
    begin
        count_next     = count_reg;
        valid_next     = valid_reg;
        done_next      = 1'b0;
        hold_vld_next  = hold_vld_reg;
        order_next     = order_reg;
        idx_next       = idx_reg;
        id_next        = id_reg;
        req_next       = req_reg;
        dl_next        = dl_reg;
        now_next       = now_reg;
        hold_id_next   = hold_id_reg;
        hold_ival_next = hold_ival_reg;
        status_next    = status_reg;
        res_id_next    = res_id_reg;
        res_ival_next  = '0;
        res_pend_next  = 1'b0;
        res_last_next  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next      = '0;
                    id_next       = timer_id;
                    req_next      = req_type;
                    dl_next       = alu;
                    now_next      = now;
                    hold_vld_next = 1'b0;
                    res_id_next   = timer_id;
                    unique case (req_type)
                        REQ_SCHEDULE:
                        begin
                            if (id_pending && !replace)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_REJECTED;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            if (!id_pending)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        REQ_QUERY:
                        begin
                            done_next     = 1'b1;
                            status_next   = id_pending ? ST_SCHEDULED : ST_NOT_FOUND;
                            res_pend_next = id_pending;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UNLINK:
            begin
                if (match)
                begin
                    for (int i = 0; i < NUM_TIMERS - 1; i++)
                        if (ID_W'(i) >= idx_reg)
                            order_next[i] = order_reg[i + 1];
                    count_next         = count_reg - CNT_W'(1);
                    valid_next[id_reg] = 1'b0;
                end
                if (match || idx_reg == ID_W'(NUM_TIMERS - 1))
                begin
                    idx_next = '0;
                    if (req_reg == REQ_CANCEL)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_CANCELLED;
                        res_id_next = id_reg;
                    end
                end
                else
                    idx_next = idx_reg + ID_W'(1);
            end
            S_INSERT:
            begin
                if (place)
                begin
                    for (int i = 1; i < NUM_TIMERS; i++)
                        if (ID_W'(i) > idx_reg)
                            order_next[i] = order_reg[i - 1];
                    order_next[idx_reg] = id_reg;
                    count_next          = count_reg + CNT_W'(1);
                    valid_next[id_reg]  = 1'b1;
                end
                if (place || idx_reg == ID_W'(NUM_TIMERS - 1))
                begin
                    done_next   = 1'b1;
                    status_next = ST_SCHEDULED;
                    res_id_next = id_reg;
                end
                else
                    idx_next = idx_reg + ID_W'(1);
            end
            S_TICK:
            begin
                // idx stays at the head; each pop shifts the list up by one
                if (due)
                begin
                    for (int i = 0; i < NUM_TIMERS - 1; i++)
                        order_next[i] = order_reg[i + 1];
                    count_next        = count_reg - CNT_W'(1);
                    valid_next[entry] = 1'b0;
                    hold_vld_next     = 1'b1;
                    hold_id_next      = entry;
                    hold_ival_next    = ival_reg[entry];
                    if (hold_vld_reg)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_EXPIRED;
                        res_id_next   = hold_id_reg;
                        res_ival_next = hold_ival_reg;
                        res_last_next = 1'b0;
                    end
                end
                else
                begin
                    done_next     = 1'b1;
                    hold_vld_next = 1'b0;
                    if (hold_vld_reg)
                    begin
                        status_next   = ST_EXPIRED;
                        res_id_next   = hold_id_reg;
                        res_ival_next = hold_ival_reg;
                    end
                    else
                    begin
                        status_next = ST_NONE;
                        res_id_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            done_reg     <= done_next;
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg     <= order_next;
        idx_reg       <= idx_next;
        id_reg        <= id_next;
        req_reg       <= req_next;
        dl_reg        <= dl_next;
        now_reg       <= now_next;
        hold_id_reg   <= hold_id_next;
        hold_ival_reg <= hold_ival_next;
        status_reg    <= status_next;
        res_id_reg    <= res_id_next;
        res_ival_reg  <= res_ival_next;
        res_pend_reg  <= res_pend_next;
        res_last_reg  <= res_last_next;
        if (dl_wr)
        begin
            deadline_reg[timer_id] <= alu;
            ival_reg[timer_id]     <= delay;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign timer_id_res = res_id_reg;
    assign interval     = res_ival_reg;
    assign pending      = res_pend_reg;
    assign last         = res_last_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the sorted timer queue: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import stq_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int N_DIRECTED  = 22;
    localparam int N_PHASE     = 4;
    localparam int PHASE_WORDS = 120;

    typedef struct packed {
        logic [2:0]        status;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] ival;
        logic              pend;
        logic              last;
    } timer_result_t;

    typedef struct packed {
        logic [1:0]        req;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dly;
        logic              rep;
        logic [TIME_W-1:0] tnow;
        logic              fixed;
        logic [2:0]        f_st;
        logic              f_pend;
    } stim_row_t;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic [1:0]        req_type     = REQ_SCHEDULE;
    logic [ID_W-1:0]   timer_id     = '0;
    logic [TIME_W-1:0] delay        = '0;
    logic              replace      = 1'b0;
    logic [TIME_W-1:0] now          = '0;
    logic              fixed_row    = 1'b0;
    logic [2:0]        fixed_status = ST_SCHEDULED;
    logic              fixed_pend   = 1'b0;

    logic              busy;
    logic              done;
    logic [2:0]        status;
    logic [ID_W-1:0]   timer_id_res;
    logic [TIME_W-1:0] interval;
    logic              pending;
    logic              last;

    // shadow copy of the timer list
    logic [ID_W-1:0]       list_order[NUM_TIMERS];
    int                    list_len   = 0;
    logic [TIME_W-1:0]     slot_deadline[NUM_TIMERS];
    logic [TIME_W-1:0]     slot_interval[NUM_TIMERS];
    logic [NUM_TIMERS-1:0] armed_mask = '0;

    timer_result_t awaited_results[$];
    stim_row_t     directed_rows[N_DIRECTED];
    int            phase_idle[N_PHASE] = '{0, 56, 29, 0};
    logic [TIME_W-1:0] clock_now = 32'hFFFF_F000;

    int cycle_count     = 0;
    int error_count     = 0;
    int words_taken     = 0;
    int ticks_taken     = 0;
    int expiries_seen   = 0;
    int results_checked = 0;

    sorted_timer_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .timer_id     (timer_id),
        .delay        (delay),
        .replace      (replace),
        .now          (now),
        .done         (done),
        .status       (status),
        .timer_id_res (timer_id_res),
        .interval     (interval),
        .pending      (pending),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic drop_from_list(input logic [ID_W-1:0] id);
        int pos;
        pos = list_len;
        for (int i = 0; i < list_len; i++)
        begin
            if (list_order[i] == id)
            begin
                pos = i;
                break;
            end
        end
        if (pos < list_len)
        begin
            for (int i = pos; i + 1 < list_len; i++)
                list_order[i] = list_order[i + 1];
            list_len--;
        end
        armed_mask[id] = 1'b0;
    endtask

    // works out the results of one accepted word and updates the shadow list
    task automatic apply_request(input stim_row_t w);
        timer_result_t     r;
        timer_result_t     held;
        int                popped;
        int                pos;
        logic [ID_W-1:0]   head;
        logic [TIME_W-1:0] diff;
        r      = '0;
        held   = '0;
        r.id   = w.id;
        r.last = 1'b1;
        case (w.req)
            REQ_TICK:
            begin
                popped = 0;
                while (list_len > 0)
                begin
                    head = list_order[0];
                    diff = slot_deadline[head] - w.tnow;
                    if (diff != '0 && !diff[TIME_W-1])
                        break;
                    drop_from_list(head);
                    if (popped > 0)
                        awaited_results.push_back(held);
                    held        = '0;
                    held.status = ST_EXPIRED;
                    held.id     = head;
                    held.ival   = slot_interval[head];
                    popped++;
                end
                if (popped == 0)
                begin
                    r.status = ST_NONE;
                    r.id     = '0;
                end
                else
                begin
                    held.last = 1'b1;
                    r         = held;
                end
                expiries_seen += popped;
            end
            REQ_SCHEDULE:
            begin
                if (armed_mask[w.id] && !w.rep)
                    r.status = ST_REJECTED;
                else
                begin
                    if (armed_mask[w.id])
                        drop_from_list(w.id);
                    slot_deadline[w.id] = w.tnow + w.dly;
                    slot_interval[w.id] = w.dly;
                    // goes after every entry that is not later; ties keep order
                    pos = list_len;
                    for (int i = 0; i < list_len; i++)
                    begin
                        diff = slot_deadline[w.id] - slot_deadline[list_order[i]];
                        if (diff[TIME_W-1])
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = list_len; i > pos; i--)
                        list_order[i] = list_order[i - 1];
                    list_order[pos] = w.id;
                    list_len++;
                    armed_mask[w.id] = 1'b1;
                    r.status = ST_SCHEDULED;
                end
            end
            REQ_CANCEL:
            begin
                if (armed_mask[w.id])
                begin
                    drop_from_list(w.id);
                    r.status = ST_CANCELLED;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
                if (armed_mask[w.id])
                begin
                    r.status = ST_SCHEDULED;
                    r.pend   = 1'b1;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
        endcase
        awaited_results.push_back(r);
    endtask

    // results are checked before the word taken at the same edge is predicted
    always @(posedge clk)
    begin
        timer_result_t got;
        timer_result_t want;
        stim_row_t     w;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{status, timer_id_res, interval, pending, last};
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"unexpected result: status %0d id %0d interval %h ",
                                  "pending %b last %b"},
                                 got.status, got.id, got.ival, got.pend, got.last);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch: expected status %0d id %0d ",
                                      "interval %h pending %b last %b, ",
                                      "got status %0d id %0d interval %h pending %b last %b"},
                                     want.status, want.id, want.ival, want.pend, want.last,
                                     got.status, got.id, got.ival, got.pend, got.last);
                    end
                end
            end
            if (start && !busy)
            begin
                w = '{req_type, timer_id, delay, replace, now,
                      fixed_row, fixed_status, fixed_pend};
                words_taken++;
                if (req_type == REQ_TICK)
                    ticks_taken++;
                apply_request(w);
                if (fixed_row)
                begin
                    // typed-in answer stands in for the predicted one
                    void'(awaited_results.pop_back());
                    awaited_results.push_back('{fixed_status, timer_id, '0, fixed_pend, 1'b1});
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(input stim_row_t w, input int idle_pct);
        int gap;
        start        <= 1'b1;
        req_type     <= w.req;
        timer_id     <= w.id;
        delay        <= w.dly;
        replace      <= w.rep;
        now          <= w.tnow;
        fixed_row    <= w.fixed;
        fixed_status <= w.f_st;
        fixed_pend   <= w.f_pend;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(20, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // mostly a running clock with small delays; some noise and far-future flush ticks
    task automatic run_random(input int n_words, input int idle_pct);
        stim_row_t w;
        int        pick;
        for (int k = 0; k < n_words; k++)
        begin
            pick  = $urandom_range(99);
            w     = '0;
            w.id  = ID_W'($urandom_range(NUM_TIMERS - 1));
            w.rep = 1'($urandom_range(1));
            w.dly = $urandom;
            w.tnow = $urandom;
            if (pick < 8)
                w.req = 2'($urandom_range(3));
            else if (pick < 48)
            begin
                w.req  = REQ_SCHEDULE;
                w.tnow = clock_now;
                if ($urandom_range(9) != 0)
                    w.dly = $urandom_range(300);
            end
            else if (pick < 72)
            begin
                w.req = REQ_TICK;
                if ($urandom_range(49) == 0)
                    clock_now = $urandom;
                else
                    clock_now += $urandom_range(80);
                w.tnow = clock_now;
                if ($urandom_range(9) == 0)
                    w.tnow = clock_now + 32'h7FFF_0000;
            end
            else if (pick < 86)
                w.req = REQ_CANCEL;
            else
                w.req = REQ_QUERY;
            send_word(w, idle_pct);
        end
    endtask

    initial
    begin
        directed_rows = '{
            '{REQ_QUERY,    4'd0,  32'h0,         1'b0, 32'h0,         1'b1, ST_NOT_FOUND, 1'b0},
            '{REQ_CANCEL,   4'd15, 32'h0,         1'b0, 32'h0,         1'b1, ST_NOT_FOUND, 1'b0},
            '{REQ_TICK,     4'd0,  32'h0,         1'b0, 32'h0,         1'b1, ST_NONE,      1'b0},
            '{REQ_SCHEDULE, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, ST_SCHEDULED, 1'b0},
            '{REQ_SCHEDULE, 4'd15, 32'h0,         1'b0, 32'h0,         1'b1, ST_REJECTED,  1'b0},
            '{REQ_QUERY,    4'd15, 32'h0,         1'b0, 32'h0,         1'b1, ST_SCHEDULED, 1'b1},
            '{REQ_SCHEDULE, 4'd0,  32'h0,         1'b1, 32'd100,       1'b1, ST_SCHEDULED, 1'b0},
            // three deadlines tie at 100
            '{REQ_SCHEDULE, 4'd1,  32'd50,        1'b0, 32'd50,        1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_SCHEDULE, 4'd2,  32'd10,        1'b0, 32'd90,        1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_SCHEDULE, 4'd3,  32'h8000_0000, 1'b0, 32'h0,         1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_SCHEDULE, 4'd1,  32'd5,         1'b1, 32'd100,       1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_TICK,     4'd9,  32'hFFFF_FFFF, 1'b1, 32'd99,        1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_TICK,     4'd0,  32'h0,         1'b0, 32'd100,       1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_CANCEL,   4'd1,  32'h0,         1'b0, 32'h0,         1'b1, ST_CANCELLED, 1'b0},
            '{REQ_CANCEL,   4'd1,  32'h0,         1'b0, 32'h0,         1'b1, ST_NOT_FOUND, 1'b0},
            '{REQ_QUERY,    4'd1,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 1'b0},
            // deadline wraps to zero
            '{REQ_SCHEDULE, 4'd4,  32'hFFFF_FFFF, 1'b0, 32'd1,         1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_SCHEDULE, 4'd5,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_TICK,     4'd0,  32'h0,         1'b0, 32'hFFFF_FFFF, 1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_TICK,     4'd0,  32'h0,         1'b0, 32'h8000_0000, 1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_SCHEDULE, 4'd6,  32'h0,         1'b0, 32'h1234_5678, 1'b0, ST_SCHEDULED, 1'b0},
            '{REQ_TICK,     4'd0,  32'h0,         1'b0, 32'hFFFF_FFFF, 1'b0, ST_SCHEDULED, 1'b0}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(directed_rows[i], 0);
        drain();
        for (int p = 0; p < N_PHASE; p++)
        begin
            run_random(PHASE_WORDS, phase_idle[p]);
            drain();
        end
        repeat (40) @(posedge clk);
        $display("%0d request words taken (%0d ticks), %0d timers expired", words_taken,
                 ticks_taken, expiries_seen);
        $display("%0d results compared, %0d errors", results_checked, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/stq_pkg.sv
rtl/sorted_timer_queue.sv
tb/sv/tb_top.sv
